/* hw/rtl/ldi_pkg.sv */
// Package for the line-average deinterlacer: widths, register indexes,
// item classes, queue entry type and the per-channel average function.
// No dependencies.
package ldi_pkg;

    localparam int unsigned PIX_W       = 32;
    localparam int unsigned RGB_W       = 24;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned NUM_CHAN    = 3;
    localparam int unsigned POS_W       = 11;
    localparam int unsigned CFG_W       = 12;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 56;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - PIX_W - 2 * POS_W;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 2048;
    localparam int unsigned MIN_WIDTH      = 1;
    localparam int unsigned MIN_HEIGHT     = 2;

    localparam logic [CFG_W-1:0]  WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0]  HEIGHT_RESET = CFG_W'(480);
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } ldi_reg_t;

    // What one accepted pixel turns into.
    typedef enum logic [2:0] {
        KIND_NONE,      // interior odd row: nothing
        KIND_FIRST,     // row 0: the pixel itself
        KIND_PASS_AVG,  // even row: pixel at r, then average at r-1
        KIND_LAST_ODD,  // last row, odd height: average at r-1 and at r
        KIND_COPY       // last row, even height: stored pixel at r
    } ldi_kind_t;

    typedef struct packed {
        logic [RGB_W-1:0] rgb0;
        logic [RGB_W-1:0] rgb1;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row0;
        logic [POS_W-1:0] row1;
        logic             two;
    } ldi_entry_t;

    function automatic logic [RGB_W-1:0] avg_rgb(input logic [RGB_W-1:0] a,
                                                 input logic [RGB_W-1:0] b);
        logic [RGB_W-1:0]  res;
        logic [CHAN_W:0]   sum;
        res = '0;
        for (int i = 0; i < NUM_CHAN; i++) begin
            sum = {1'b0, a[i*CHAN_W +: CHAN_W]} + {1'b0, b[i*CHAN_W +: CHAN_W]};
            res[i*CHAN_W +: CHAN_W] = sum[CHAN_W:1];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/ldi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module ldi_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/ldi_front.sv */
// Front end: accepts pixels, tracks column and row, classifies each pixel,
// reads and writes the even-line store and builds queue entries.
// Depends on ldi_pkg and ldi_ram.
module ldi_front #(
    parameter int unsigned MAX_WIDTH  = ldi_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = ldi_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ldi_pkg::CFG_W-1:0]  frame_width,
    input  logic [ldi_pkg::CFG_W-1:0]  frame_height,
    input  logic                       pix_valid,
    output logic                       pix_ready,
    input  logic [ldi_pkg::RGB_W-1:0]  pix_rgb,
    output logic                       push_valid,
    input  logic                       push_ready,
    output ldi_pkg::ldi_entry_t        push_entry
);
    import ldi_pkg::*;

    localparam int unsigned CW   = $clog2(MAX_WIDTH);
    localparam int unsigned RW   = $clog2(MAX_HEIGHT);
    localparam int unsigned WCMP = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int unsigned HCMP = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    logic [WCMP-1:0] width_ext;
    logic [HCMP-1:0] height_ext;
    logic [CW:0]     eff_w;
    logic [RW:0]     eff_h;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic          col_wrap;
    logic [RW:0]   row_pre;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic          is_last_row;
    ldi_kind_t     kind;
    logic          accept;

    logic             b_valid_reg;
    ldi_kind_t        b_kind_reg;
    logic [RGB_W-1:0] b_rgb_reg;
    logic [POS_W-1:0] b_col_reg;
    logic [POS_W-1:0] b_row_reg;
    logic [POS_W-1:0] b_rowm1_reg;
    logic [RGB_W-1:0] stored;
    logic [RGB_W-1:0] avg;
    logic             b_advance;

    // Clamp the geometry registers to the supported range.
    always_comb begin
        width_ext  = WCMP'(frame_width);
        height_ext = HCMP'(frame_height);
        if (width_ext < WCMP'(MIN_WIDTH)) begin
            eff_w = (CW + 1)'(MIN_WIDTH);
        end else if (width_ext > WCMP'(MAX_WIDTH)) begin
            eff_w = (CW + 1)'(MAX_WIDTH);
        end else begin
            eff_w = width_ext[CW:0];
        end
        if (height_ext < HCMP'(MIN_HEIGHT)) begin
            eff_h = (RW + 1)'(MIN_HEIGHT);
        end else if (height_ext > HCMP'(MAX_HEIGHT)) begin
            eff_h = (RW + 1)'(MAX_HEIGHT);
        end else begin
            eff_h = height_ext[RW:0];
        end
    end

    // Position of this pixel; re-wrap first in case the geometry shrank.
    always_comb begin
        col_wrap = {1'b0, col_reg} >= eff_w;
        cur_col  = col_wrap ? '0 : col_reg;
        row_pre  = col_wrap ? {1'b0, row_reg} + (RW + 1)'(1) : {1'b0, row_reg};
        cur_row  = (row_pre >= eff_h) ? '0 : row_pre[RW-1:0];

        col_inc = {1'b0, cur_col} + (CW + 1)'(1);
        row_inc = {1'b0, cur_row} + (RW + 1)'(1);
        if (col_inc >= eff_w) begin
            col_next = '0;
            row_next = (row_inc >= eff_h) ? '0 : row_inc[RW-1:0];
        end else begin
            col_next = col_inc[CW-1:0];
            row_next = cur_row;
        end

        is_last_row = {1'b0, cur_row} == (eff_h - (RW + 1)'(1));
        if (!cur_row[0]) begin
            if (cur_row == '0) begin
                kind = KIND_FIRST;
            end else if (is_last_row) begin
                kind = KIND_LAST_ODD;
            end else begin
                kind = KIND_PASS_AVG;
            end
        end else if (is_last_row) begin
            kind = KIND_COPY;
        end else begin
            kind = KIND_NONE;
        end
    end

    assign b_advance = !b_valid_reg || (b_kind_reg == KIND_NONE) || push_ready;
    assign pix_ready = b_advance;
    assign accept    = pix_valid && pix_ready;

    ldi_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (accept && !cur_row[0]),
        .wr_addr (cur_col),
        .wr_data (pix_rgb),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (stored)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (b_advance) begin
                b_valid_reg <= accept;
            end
        end
    end

    // Hold the classified item while the store read completes.
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_kind_reg  <= kind;
            b_rgb_reg   <= pix_rgb;
            b_col_reg   <= POS_W'(cur_col);
            b_row_reg   <= POS_W'(cur_row);
            b_rowm1_reg <= POS_W'(cur_row - RW'(1));
        end
    end

    assign avg        = avg_rgb(stored, b_rgb_reg);
    assign push_valid = b_valid_reg && (b_kind_reg != KIND_NONE);

    always_comb begin
        push_entry.col  = b_col_reg;
        push_entry.rgb0 = b_rgb_reg;
        push_entry.rgb1 = b_rgb_reg;
        push_entry.row0 = b_row_reg;
        push_entry.row1 = b_row_reg;
        push_entry.two  = 1'b0;
        case (b_kind_reg)
            KIND_PASS_AVG: begin
                push_entry.rgb1 = avg;
                push_entry.row1 = b_rowm1_reg;
                push_entry.two  = 1'b1;
            end
            KIND_LAST_ODD: begin
                push_entry.rgb0 = avg;
                push_entry.row0 = b_rowm1_reg;
                push_entry.rgb1 = avg;
                push_entry.two  = 1'b1;
            end
            KIND_COPY: begin
                push_entry.rgb0 = stored;
            end
            default: begin
            end
        endcase
    end

endmodule

/* hw/rtl/ldi_queue.sv */
// Short register FIFO of classified entries between front and back end.
// Depends on ldi_pkg.
module ldi_queue #(
    parameter int unsigned DEPTH = ldi_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  ldi_pkg::ldi_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_en,
    output ldi_pkg::ldi_entry_t pop_entry
);
    import ldi_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW = $clog2(DEPTH + 1);

    ldi_entry_t     slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign push_ready = count_reg != NW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_en && pop_valid;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hw/rtl/ldi_back.sv */
// Back end: expands each queue entry into one or two results and drives
// the output register. Depends on ldi_pkg.
module ldi_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pop_valid,
    output logic                              pop_en,
    input  ldi_pkg::ldi_entry_t               pop_entry,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ldi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);
    import ldi_pkg::*;

    logic             out_valid_reg;
    logic [RGB_W-1:0] out_rgb_reg;
    logic [POS_W-1:0] out_col_reg;
    logic [POS_W-1:0] out_row_reg;
    logic             out_last_reg;
    logic             second_reg, second_next;
    logic             out_free, load;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign load     = out_free && pop_valid;

    // Release the entry once its final result has been loaded.
    always_comb begin
        second_next = second_reg;
        pop_en      = 1'b0;
        if (load) begin
            if (!second_reg && pop_entry.two) begin
                second_next = 1'b1;
            end else begin
                second_next = 1'b0;
                pop_en      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end else begin
            second_reg <= second_next;
            if (out_free) begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_col_reg  <= pop_entry.col;
            out_rgb_reg  <= second_reg ? pop_entry.rgb1 : pop_entry.rgb0;
            out_row_reg  <= second_reg ? pop_entry.row1 : pop_entry.row0;
            out_last_reg <= second_reg || !pop_entry.two;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_row_reg, out_col_reg,
                            ALPHA_OPAQUE, out_rgb_reg};

endmodule

/* hw/rtl/line_average_deinterlacer_top.sv */
// Top level of the line-average deinterlacer: configuration registers and
// the front end, entry queue and back end. Depends on ldi_pkg, ldi_front,
// ldi_queue and ldi_back.
//
// Pixels enter in raster order on the s_axis channel; frame_width and
// frame_height (indexes 0 and 1 on the write port) set the geometry. The
// user must write them only while the block is idle; the block itself
// does not enforce this. Even rows pass through and are kept in a one-line
// store; each interior odd row is dropped on arrival and rebuilt as the
// per-channel average of the even rows around it, emitted right after the
// even row below. At even height the last row repeats the row before it;
// at odd height it takes that row's average. Results carry column and
// row, so they leave out of raster order, with alpha forced to 255. Rate:
// the output register moves one result per cycle while m_axis_tready is
// high. A result passes the store read register, the queue and the output
// register; a four-entry queue decouples the pixel input from output
// stalls. No clearing pass is needed after reset.
module line_average_deinterlacer_top #(
    parameter int unsigned MAX_WIDTH  = ldi_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = ldi_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [ldi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ldi_pkg::CFG_W-1:0]        cfg_wdata,
    // pixel input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ldi_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [31:0] pixel_in
    // results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ldi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [31:0] pixel_out,
                                                            // [42:32] column,
                                                            // [53:43] row
    output logic                             m_axis_tlast   // last_of_run
);
    import ldi_pkg::*;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    logic       push_valid, push_ready;
    ldi_entry_t push_entry;
    logic       pop_valid, pop_en;
    ldi_entry_t pop_entry;

    // Take a register write whenever the enable is high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Accept and classify pixels; the top byte of the pixel is ignored.
    ldi_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pix_valid    (s_axis_tvalid),
        .pix_ready    (s_axis_tready),
        .pix_rgb      (s_axis_tdata[RGB_W-1:0]),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    ldi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_entry  (pop_entry)
    );

    // Expand entries into result transactions.
    ldi_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_en        (pop_en),
        .pop_entry     (pop_entry),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* hw/rtl/ldi_checker.sv */
// Port-level checker for the line-average deinterlacer, bound to the top.
// Depends on ldi_pkg and line_average_deinterlacer_top.
module ldi_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [ldi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             m_axis_tlast
);
    import ldi_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Alpha is forced opaque on every result.
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[PIX_W-1:RGB_W] == ALPHA_OPAQUE)
        else $error("alpha not opaque");

    // The second result of a pair follows at once.
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second result of a pair missing");

    // Both results of a pair share the column.
    a_pair_column: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tdata[PIX_W+POS_W-1:PIX_W] == $past(m_axis_tdata[PIX_W+POS_W-1:PIX_W]))
        else $error("pair column mismatch");

endmodule

bind line_average_deinterlacer_top ldi_checker u_ldi_checker (.*);
